// ===== hw/rtl/swmm_pkg.sv =====
// ----------------------------------------------------------------------------
// Sliding window min/max package
// Shared widths, item types and sequencer states for the two-stack window.
// ----------------------------------------------------------------------------
package swmm_pkg;

  localparam int MAX_WINDOW  = 64;
  localparam int DATA_W      = 32;
  localparam int CFG_W       = 7;
  localparam int CNT_W       = $clog2(MAX_WINDOW + 1);
  localparam int ADDR_W      = $clog2(MAX_WINDOW);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic {
    OP_PUSH,
    OP_RESTART
  } op_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] sample;
    op_e                      op;
  } item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] lo;
    logic signed [DATA_W-1:0] hi;
  } mm_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TRIM,
    ST_XFER,
    ST_EMIT
  } st_e;

endpackage

// ===== hw/rtl/sliding_window_min_max.sv =====
// ----------------------------------------------------------------------------
// Sliding window minimum and maximum
// Running min/max over the last window_size signed samples, two-stack queue.
// ----------------------------------------------------------------------------
// Samples arrive on the in_* channel, each with a restart flag that empties
// the window before the sample is taken. Once the window holds window_size
// samples, every sample produces one out_* transaction carrying the window's
// minimum and maximum; until then a sample produces nothing.
// The window size is written on the cfg_* channel; the user must write it
// only while the block is idle, which the block itself does not enforce.
// Zero is treated as one and values above 64 as 64. In steady state a
// sample is dequeued, the oldest sample is trimmed and the new one pushed.
// When the front stack runs empty, the back stack is moved over at one
// entry per cycle through the stack memory ports, once per window. A short
// queue sits between the input stage and the stack engine, and results wait
// in an output register, so input is still taken while the receiver stalls
// until the queue fills up.
// Reset empties both stacks and sets the window size to one; the stack
// memories themselves are not cleared.
// ----------------------------------------------------------------------------
module sliding_window_min_max (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [swmm_pkg::DATA_W-1:0] sample_i,
  input  logic                        restart_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [swmm_pkg::CFG_W-1:0]  window_size_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [swmm_pkg::DATA_W-1:0] window_min_o,
  output logic [swmm_pkg::DATA_W-1:0] window_max_o
);
  import swmm_pkg::*;

  logic             f2q_valid;
  logic             f2q_ready;
  item_t            f2q_item;
  logic             q2e_valid;
  logic             q2e_ready;
  item_t            q2e_item;
  logic [CNT_W-1:0] win;

  swmm_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .sample_i      (sample_i),
    .restart_i     (restart_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .window_size_i (window_size_i),
    .item_valid_o  (f2q_valid),
    .item_ready_i  (f2q_ready),
    .item_o        (f2q_item),
    .win_o         (win)
  );

  swmm_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f2q_valid),
    .wr_ready_o (f2q_ready),
    .wr_item_i  (f2q_item),
    .rd_valid_o (q2e_valid),
    .rd_ready_i (q2e_ready),
    .rd_item_o  (q2e_item)
  );

  swmm_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q2e_valid),
    .item_ready_o (q2e_ready),
    .item_i       (q2e_item),
    .win_i        (win),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .window_min_o (window_min_o),
    .window_max_o (window_max_o)
  );

endmodule

// ===== hw/rtl/swmm_front.sv =====
// ----------------------------------------------------------------------------
// Sliding window min/max front end
// Accepts input transactions into a holding register, tags them as plain or
// restarting pushes, and keeps the window size register and its clamped value.
// ----------------------------------------------------------------------------
module swmm_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [swmm_pkg::DATA_W-1:0] sample_i,
  input  logic                       restart_i,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [swmm_pkg::CFG_W-1:0] window_size_i,
  output logic                       item_valid_o,
  input  logic                       item_ready_i,
  output swmm_pkg::item_t            item_o,
  output logic [swmm_pkg::CNT_W-1:0] win_o
);
  import swmm_pkg::*;

  logic             hold_valid_q;
  item_t            hold_q;
  logic [CFG_W-1:0] window_size_q;

  assign in_ready_o   = !hold_valid_q || item_ready_i;
  assign cfg_ready_o  = 1'b1;
  assign item_valid_o = hold_valid_q;
  assign item_o       = hold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q  <= 1'b0;
      window_size_q <= CFG_W'(1);
    end else begin
      if (in_valid_i && in_ready_o) begin
        hold_valid_q <= 1'b1;
      end else if (item_ready_i) begin
        hold_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        window_size_q <= window_size_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      hold_q.sample <= sample_i;
      hold_q.op     <= restart_i ? OP_RESTART : OP_PUSH;
    end
  end

  always_comb begin
    if (window_size_q == '0) begin
      win_o = CNT_W'(1);
    end else if (int'(window_size_q) > MAX_WINDOW) begin
      win_o = CNT_W'(MAX_WINDOW);
    end else begin
      win_o = CNT_W'(window_size_q);
    end
  end

endmodule

// ===== hw/rtl/swmm_queue.sv =====
// ----------------------------------------------------------------------------
// Sliding window min/max item queue
// Short FIFO that decouples the front end from the stack engine.
// ----------------------------------------------------------------------------
module swmm_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_valid_i,
  output logic            wr_ready_o,
  input  swmm_pkg::item_t wr_item_i,
  output logic            rd_valid_o,
  input  logic            rd_ready_i,
  output swmm_pkg::item_t rd_item_o
);
  import swmm_pkg::*;

  item_t             entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              wr_en;
  logic              rd_en;

  assign wr_ready_o = count_q != QCNT_W'(QUEUE_DEPTH);
  assign rd_valid_o = count_q != '0;
  assign rd_item_o  = entry_q[rd_ptr_q];
  assign wr_en      = wr_valid_i && wr_ready_o;
  assign rd_en      = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (rd_en && !wr_en) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_q[wr_ptr_q] <= wr_item_i;
    end
  end

endmodule

// ===== hw/rtl/swmm_engine.sv =====
// ----------------------------------------------------------------------------
// Sliding window min/max stack engine
// Holds the front and back stacks, trims the window, moves the back stack
// onto the front stack when needed, pushes samples and registers results.
// ----------------------------------------------------------------------------
module swmm_engine (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        item_valid_i,
  output logic                        item_ready_o,
  input  swmm_pkg::item_t             item_i,
  input  logic [swmm_pkg::CNT_W-1:0]  win_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [swmm_pkg::DATA_W-1:0] window_min_o,
  output logic [swmm_pkg::DATA_W-1:0] window_max_o
);
  import swmm_pkg::*;

  st_e                      state_q, state_d;
  logic [CNT_W-1:0]         f_q, f_d;
  logic [CNT_W-1:0]         b_q, b_d;
  logic [CNT_W-1:0]         fill_q, fill_d;
  logic                     xrd_q;
  logic                     rd_pend_q;
  logic                     out_valid_q;
  logic signed [DATA_W-1:0] sample_q;
  logic signed [DATA_W-1:0] bmin_q;
  logic signed [DATA_W-1:0] bmax_q;
  mm_t                      ftop_q;
  logic signed [DATA_W-1:0] out_min_q;
  logic signed [DATA_W-1:0] out_max_q;

  mm_t                      front_mem [MAX_WINDOW];
  logic signed [DATA_W-1:0] back_mem  [MAX_WINDOW];
  mm_t                      front_rdata_q;
  logic signed [DATA_W-1:0] back_rdata_q;

  logic                     take;
  logic                     do_pop;
  logic                     do_push;
  logic                     x_issue;
  logic                     x_push;
  logic                     emit;
  logic                     trim_more;
  logic                     pop_rd;
  logic [CNT_W-1:0]         pop_idx;
  logic [CNT_W-1:0]         back_idx;
  logic [CNT_W-1:0]         fill_inc;
  logic signed [DATA_W-1:0] push_lo;
  logic signed [DATA_W-1:0] push_hi;
  mm_t                      x_entry;
  logic signed [DATA_W-1:0] emit_lo;
  logic signed [DATA_W-1:0] emit_hi;

  assign trim_more    = fill_q >= win_i;
  assign fill_inc     = fill_q + CNT_W'(1);
  assign pop_idx      = f_q - CNT_W'(2);
  assign back_idx     = b_q - CNT_W'(1);
  assign pop_rd       = do_pop && (f_q >= CNT_W'(2));
  assign item_ready_o = take;
  assign out_valid_o  = out_valid_q;
  assign window_min_o = out_min_q;
  assign window_max_o = out_max_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          state_d = ST_TRIM;
        end
      end
      ST_TRIM: begin
        if (trim_more) begin
          if (f_q == '0) begin
            state_d = ST_XFER;
          end
        end else if (fill_inc == win_i) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_XFER: begin
        if (b_q == '0 && !xrd_q) begin
          state_d = ST_TRIM;
        end
      end
      ST_EMIT: begin
        if (emit) begin
          state_d = item_valid_i ? ST_TRIM : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    take    = 1'b0;
    do_pop  = 1'b0;
    do_push = 1'b0;
    x_issue = 1'b0;
    x_push  = 1'b0;
    emit    = 1'b0;
    unique case (state_q)
      ST_IDLE: take = item_valid_i;
      ST_TRIM: begin
        if (trim_more) begin
          do_pop = f_q != '0;
        end else begin
          do_push = 1'b1;
        end
      end
      ST_XFER: begin
        x_issue = b_q != '0;
        x_push  = xrd_q;
      end
      ST_EMIT: begin
        emit = !out_valid_q || out_ready_i;
        take = emit && item_valid_i;
      end
      default: ;
    endcase
  end

  always_comb begin
    f_d    = f_q;
    b_d    = b_q;
    fill_d = fill_q;
    if (take && item_i.op == OP_RESTART) begin
      f_d    = '0;
      b_d    = '0;
      fill_d = '0;
    end
    if (do_pop) begin
      f_d    = f_q - CNT_W'(1);
      fill_d = fill_q - CNT_W'(1);
    end
    if (do_push) begin
      b_d    = b_q + CNT_W'(1);
      fill_d = fill_inc;
    end
    if (x_issue) begin
      b_d = back_idx;
    end
    if (x_push) begin
      f_d = f_q + CNT_W'(1);
    end
  end

  always_comb begin
    push_lo = (b_q == '0 || sample_q < bmin_q) ? sample_q : bmin_q;
    push_hi = (b_q == '0 || sample_q > bmax_q) ? sample_q : bmax_q;
    x_entry.lo = (f_q == '0 || back_rdata_q < ftop_q.lo) ? back_rdata_q : ftop_q.lo;
    x_entry.hi = (f_q == '0 || back_rdata_q > ftop_q.hi) ? back_rdata_q : ftop_q.hi;
    emit_lo = (f_q != '0 && ftop_q.lo < bmin_q) ? ftop_q.lo : bmin_q;
    emit_hi = (f_q != '0 && ftop_q.hi > bmax_q) ? ftop_q.hi : bmax_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      f_q         <= '0;
      b_q         <= '0;
      fill_q      <= '0;
      xrd_q       <= 1'b0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      f_q       <= f_d;
      b_q       <= b_d;
      fill_q    <= fill_d;
      xrd_q     <= x_issue;
      rd_pend_q <= pop_rd;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      sample_q <= item_i.sample;
    end
    if (do_push) begin
      bmin_q <= push_lo;
      bmax_q <= push_hi;
    end
    if (x_push) begin
      ftop_q <= x_entry;
    end else if (rd_pend_q) begin
      ftop_q <= front_rdata_q;
    end
    if (emit) begin
      out_min_q <= emit_lo;
      out_max_q <= emit_hi;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      back_mem[b_q[ADDR_W-1:0]] <= sample_q;
    end
    if (x_issue) begin
      back_rdata_q <= back_mem[back_idx[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (x_push) begin
      front_mem[f_q[ADDR_W-1:0]] <= x_entry;
    end
    if (pop_rd) begin
      front_rdata_q <= front_mem[pop_idx[ADDR_W-1:0]];
    end
  end

endmodule

// ===== hw/rtl/swmm_checker.sv =====
// ----------------------------------------------------------------------------
// Sliding window min/max port checker
// Watches the top-level ports for ordering and result consistency.
// ----------------------------------------------------------------------------
module swmm_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [swmm_pkg::DATA_W-1:0] window_min_o,
  input logic [swmm_pkg::DATA_W-1:0] window_max_o
);
  import swmm_pkg::*;

  localparam int CREDIT_W = 16;

  logic [CREDIT_W-1:0] credit_q;
  logic                in_txn;
  logic                out_txn;

  assign in_txn  = in_valid_i && in_ready_o;
  assign out_txn = out_valid_o && out_ready_i;

  // Outstanding input transactions; it sticks once saturated.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q <= '0;
    end else if (credit_q != '1) begin
      credit_q <= credit_q + CREDIT_W'(in_txn) - CREDIT_W'(out_txn);
    end
  end

  a_out_needs_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> credit_q != '0)
    else $error("result offered without a matching input transaction");

  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $signed(window_min_o) <= $signed(window_max_o))
    else $error("window minimum exceeds window maximum");

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result withdrawn before its transaction");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(window_min_o) && $stable(window_max_o))
    else $error("result changed while stalled");

endmodule

bind sliding_window_min_max swmm_checker u_swmm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .window_min_o (window_min_o),
  .window_max_o (window_max_o)
);

// ===== sim/window_minmax_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window min/max checker
// Watches the sample, window size and result channels of the block. It keeps
// its own copy of the window contents, works out the minimum and maximum
// that each accepted sample should produce, and compares every accepted
// result with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module window_minmax_checker
  import swmm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [DATA_W-1:0] sample_i,
  input  logic              restart_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [CFG_W-1:0]  window_size_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [DATA_W-1:0] window_min_i,
  input  logic [DATA_W-1:0] window_max_i,
  output int                mismatch_count_o,
  output int                extremes_pending_o
);

  logic signed [DATA_W-1:0] window_q[$];
  mm_t                      extremes_due_q[$];
  logic [CFG_W-1:0]         size_reg;
  int                       mismatches;
  int                       span;
  logic signed [DATA_W-1:0] run_lo;
  logic signed [DATA_W-1:0] run_hi;
  mm_t                      want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q.delete();
      extremes_due_q.delete();
      size_reg = 7'd1;
      mismatches = 0;
      mismatch_count_o <= 0;
      extremes_pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        size_reg = window_size_i;
      end

      // Results always stem from earlier samples, so they are checked first.
      if (out_valid_i && out_ready_i) begin
        if (extremes_due_q.size() == 0) begin
          if (mismatches < 10) begin
            $display("window extremes: unexpected result min=%0d max=%0d",
                     $signed(window_min_i), $signed(window_max_i));
          end
          mismatches++;
        end else begin
          want = extremes_due_q[0];
          extremes_due_q.delete(0);
          if (window_min_i !== want.lo || window_max_i !== want.hi) begin
            if (mismatches < 10) begin
              $display("window extremes: min expected %0d got %0d, max expected %0d got %0d",
                       want.lo, $signed(window_min_i), want.hi, $signed(window_max_i));
            end
            mismatches++;
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        span = (size_reg == 0) ? 1 : (size_reg > MAX_WINDOW) ? MAX_WINDOW : size_reg;
        if (restart_i) begin
          window_q.delete();
        end
        // A shrunk window drops its oldest samples before the new one enters.
        while (window_q.size() >= span) begin
          window_q.delete(0);
        end
        window_q.push_back(sample_i);
        if (window_q.size() == span) begin
          run_lo = VAL_MAX;
          run_hi = VAL_MIN;
          foreach (window_q[i]) begin
            if (window_q[i] < run_lo) begin
              run_lo = window_q[i];
            end
            if (window_q[i] > run_hi) begin
              run_hi = window_q[i];
            end
          end
          extremes_due_q.push_back('{lo: run_lo, hi: run_hi});
        end
      end

      mismatch_count_o <= mismatches;
      extremes_pending_o <= extremes_due_q.size();
    end
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window min/max testbench
// Drives the block with a short directed sequence of extreme and special
// samples, then with phases of random samples at a range of window sizes
// and idling patterns, including a long receiver hold-off. A checker beside
// the block predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import swmm_pkg::*;

  localparam int STALL_LIMIT   = 4000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 300;
  localparam int N_PHASES      = 10;
  localparam int HOLD_PHASE    = 1;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid    = 1'b0;
  logic              in_ready;
  logic [DATA_W-1:0] sample      = '0;
  logic              restart     = 1'b0;
  logic              cfg_valid   = 1'b0;
  logic              cfg_ready;
  logic [CFG_W-1:0]  window_size = '0;
  logic              out_valid;
  logic              out_ready   = 1'b0;
  logic [DATA_W-1:0] window_min;
  logic [DATA_W-1:0] window_max;

  int   mismatch_count;
  int   extremes_pending;
  int   idle_cycles   = 0;
  int   tx_idle_pct   = 0;
  int   rx_stall_pct  = 0;
  logic hold_req      = 1'b0;
  logic hold_done     = 1'b0;
  int   hold_left     = 0;

  int phase_size[N_PHASES]  = '{0, 64, 2, 127, 17, 65, 1, 40, 5, 33};
  int phase_mode[N_PHASES]  = '{0, 0, 1, 2, 3, 3, 2, 1, 3, 0};
  int phase_items[N_PHASES] = '{60, 150, 60, 120, 80, 100, 40, 80, 60, 80};

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  sliding_window_min_max u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .sample_i      (sample),
    .restart_i     (restart),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .window_size_i (window_size),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .window_min_o  (window_min),
    .window_max_o  (window_max)
  );

  window_minmax_checker u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_ready_i         (in_ready),
    .sample_i           (sample),
    .restart_i          (restart),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_i        (cfg_ready),
    .window_size_i      (window_size),
    .out_valid_i        (out_valid),
    .out_ready_i        (out_ready),
    .window_min_i       (window_min),
    .window_max_i       (window_max),
    .mismatch_count_o   (mismatch_count),
    .extremes_pending_o (extremes_pending)
  );

  // Receiver: random stalls, plus one long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_sample(input logic [DATA_W-1:0] value, input logic clear);
    int   gap;
    logic taken;
    gap = 0;
    while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      gap++;
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    sample   <= value;
    restart  <= clear;
    do begin
      @(negedge clk_i);
      taken = in_ready;
      @(posedge clk_i);
    end while (!taken);
  endtask

  task automatic write_window(input logic [CFG_W-1:0] value);
    logic taken;
    in_valid <= 1'b0;
    do @(posedge clk_i); while (extremes_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid   <= 1'b1;
    window_size <= value;
    do begin
      @(negedge clk_i);
      taken = cfg_ready;
      @(posedge clk_i);
    end while (!taken);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] prev_value;
    int                span;
    int                mode;

    prev_value = '0;
    phase_size[7] = $urandom_range(1, 64);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Window of one straight after reset: every sample is its own result.
    send_sample(32'h0000_0000, 1'b0);
    send_sample(VAL_MAX, 1'b0);
    send_sample(VAL_MIN, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'h0000_0001, 1'b0);
    send_sample(32'h5555_5555, 1'b1);

    write_window(7'd3);
    send_sample(32'd5, 1'b0);
    send_sample(-32'sd7, 1'b0);
    send_sample(VAL_MAX, 1'b0);
    send_sample(VAL_MIN, 1'b0);
    send_sample(32'd0, 1'b0);
    send_sample(32'd2, 1'b0);
    send_sample(32'd9, 1'b1);
    send_sample(32'd10, 1'b0);
    send_sample(32'd11, 1'b0);
    send_sample(32'd4, 1'b0);
    send_sample(32'd4, 1'b0);
    send_sample(32'd4, 1'b0);
    send_sample(32'hAAAA_AAAA, 1'b0);

    for (int p = 0; p < N_PHASES; p++) begin
      write_window(CFG_W'(phase_size[p]));
      mode = phase_mode[p];
      tx_idle_pct = (mode == 1) ? 79 : (mode == 3) ? 37 : 0;
      rx_stall_pct <= (mode == 2) ? 79 : (mode == 3) ? 37 : 0;
      span = (phase_size[p] == 0) ? 1 : (phase_size[p] > MAX_WINDOW) ? MAX_WINDOW
                                                                       : phase_size[p];
      for (int n = 0; n < phase_items[p]; n++) begin
        if (p == HOLD_PHASE && n == 80) begin
          hold_req <= 1'b1;
        end
        case ($urandom_range(0, 7))
          0:       value = VAL_MIN;
          1:       value = VAL_MAX;
          2:       value = $urandom_range(0, 20) - 10;
          3:       value = prev_value + $urandom_range(0, 5);
          4:       value = prev_value - $urandom_range(0, 5);
          default: value = $urandom();
        endcase
        prev_value = value;
        send_sample(value, $urandom_range(0, 4 * span + 20) == 0);
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk_i); while (extremes_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && extremes_pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
